/* design/sfrb_pkg.sv */
package sfrb_pkg;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned BYTES_W  = 10;
  localparam int unsigned WANT_W   = 7;
  localparam int unsigned LEVEL_W  = 10;
  localparam int unsigned PKT_W    = BYTES_W - 2;

  typedef enum logic [1:0] {
    REQ_PUSH  = 2'd0,
    REQ_POP   = 2'd1,
    REQ_FLUSH = 2'd2
  } req_e;

  // right sample in the high half, left in the low half
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] right;
    logic signed [SAMPLE_W-1:0] left;
  } frame_t;

endpackage

/* design/stereo_frame_ring_buffer.sv */
// channel   dir  tdata fields (low bit up)                      tuser / tlast
// s_axis    in   packet_bytes[9:0] left_in[25:10]              tuser: req_type[1:0]
//                right_in[41:26] pop_frames[48:42]             packet_start[2]
// m_axis    out  left_out[15:0] right_out[31:16] level[41:32]  tuser: frame_valid[0]
//                                                              push_accepted[1]; tlast: last
//
// Push, flush and status requests each answer with one beat from the output register.
// A pop of n frames streams one frame per cycle while m_axis is ready, each frame
// read first into a register from the frame memory; no new beat is taken meanwhile.
// Reset clears indexes and the open packet; the frame memory is not cleared.
// A stall on m_axis holds the output register and, once a fetched frame waits, stops further memory reads.
module stereo_frame_ring_buffer #(
  parameter int unsigned RING_FRAMES    = 1024,
  parameter int unsigned MAX_POP_FRAMES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // packet_bytes, left_in, right_in, pop_frames (low bit up), zero fill
  input  logic [55:0] s_axis_tdata_i,
  // req_type, packet_start (low bit up)
  input  logic [2:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // left_out, right_out, level (low bit up), zero fill
  output logic [47:0] m_axis_tdata_o,
  // frame_valid, push_accepted (low bit up)
  output logic [1:0]  m_axis_tuser_o,
  output logic        m_axis_tlast_o
);

  localparam int unsigned AW = $clog2(RING_FRAMES);
  localparam int unsigned SW = sfrb_pkg::SAMPLE_W;
  localparam int unsigned WW = sfrb_pkg::WANT_W;
  localparam int unsigned PW = sfrb_pkg::PKT_W;
  localparam int unsigned LW = sfrb_pkg::LEVEL_W;
  localparam logic [WW-1:0] MaxPop = WW'(MAX_POP_FRAMES);
  localparam logic [AW-1:0] SpaceMax = AW'(RING_FRAMES - 1);

  typedef enum logic {ST_IDLE, ST_POP} state_e;

  state_e state_q;

  sfrb_pkg::frame_t mem [RING_FRAMES];
  sfrb_pkg::frame_t rdata_q;

  logic [AW-1:0] wr_q, rd_q;
  logic [PW-1:0] frames_left_q;
  logic [WW-1:0] issue_q, emit_q;
  logic [AW-1:0] plvl_q;
  logic          rdv_q;

  logic          out_valid_q;
  logic [SW-1:0] out_left_q, out_right_q;
  logic          out_fv_q, out_acc_q, out_last_q;
  logic [AW-1:0] out_lvl_q;

  sfrb_pkg::req_e req;
  logic           start;
  logic [PW-1:0]  n_pkt;
  logic [WW-1:0]  want;
  sfrb_pkg::frame_t din;

  logic              out_free, accept, issue, emit, fits, store;
  logic [AW-1:0]     level, space;
  logic [PW-1:0]     left_cnt;
  logic [WW-1:0]     want_sat, pop_n;
  logic [AW+WW-1:0]  want_x, lvl_x, n_x;
  logic [AW+LW-1:0]  lvl_ext;

  assign req        = sfrb_pkg::req_e'(s_axis_tuser_i[1:0]);
  assign start      = s_axis_tuser_i[2];
  assign n_pkt      = s_axis_tdata_i[9:2];
  assign din.left   = s_axis_tdata_i[25:10];
  assign din.right  = s_axis_tdata_i[41:26];
  assign want       = s_axis_tdata_i[48:42];

  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == ST_IDLE) && out_free;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  assign level = wr_q - rd_q;
  assign space = SpaceMax - level;
  assign fits  = (n_pkt != '0) && ({{AW{1'b0}}, n_pkt} <= {{PW{1'b0}}, space});

  // an open packet is one that still expects frames
  assign left_cnt = start ? (fits ? n_pkt : '0) : frames_left_q;
  assign store    = accept && (req == sfrb_pkg::REQ_PUSH) && (left_cnt != '0);

  assign want_sat = (want > MaxPop) ? MaxPop : want;
  assign want_x   = {{AW{1'b0}}, want_sat};
  assign lvl_x    = {{WW{1'b0}}, level};
  assign n_x      = (want_x < lvl_x) ? want_x : lvl_x;
  assign pop_n    = n_x[WW-1:0];

  // read ahead only when the fetched frame can move on
  assign emit  = rdv_q && out_free;
  assign issue = (state_q == ST_POP) && (issue_q != '0) && (!rdv_q || emit);

  // pushes and pops never overlap, so a read never meets a write to its entry
  always_ff @(posedge clk_i) begin
    if (store) begin
      mem[wr_q] <= din;
    end
    if (issue) begin
      rdata_q <= mem[rd_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      wr_q          <= '0;
      rd_q          <= '0;
      frames_left_q <= '0;
      issue_q       <= '0;
      emit_q        <= '0;
      plvl_q        <= '0;
      rdv_q         <= 1'b0;
      out_valid_q   <= 1'b0;
      out_left_q    <= '0;
      out_right_q   <= '0;
      out_fv_q      <= 1'b0;
      out_acc_q     <= 1'b0;
      out_last_q    <= 1'b0;
      out_lvl_q     <= '0;
    end else begin
      if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      rdv_q <= issue || (rdv_q && !emit);
      if (issue) begin
        rd_q    <= rd_q + 1'b1;
        issue_q <= issue_q - 1'b1;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            out_valid_q <= 1'b1;
            out_left_q  <= '0;
            out_right_q <= '0;
            out_fv_q    <= 1'b0;
            out_acc_q   <= 1'b0;
            out_last_q  <= 1'b1;
            out_lvl_q   <= level;
            unique case (req)
              sfrb_pkg::REQ_PUSH: begin
                if (store) begin
                  wr_q          <= wr_q + 1'b1;
                  frames_left_q <= left_cnt - 1'b1;
                  out_acc_q     <= 1'b1;
                  out_lvl_q     <= level + 1'b1;
                end else begin
                  frames_left_q <= left_cnt;
                end
              end
              sfrb_pkg::REQ_POP: begin
                if (pop_n != '0) begin
                  // hold the result slot for the first frame
                  out_valid_q <= 1'b0;
                  state_q     <= ST_POP;
                  issue_q     <= pop_n;
                  emit_q      <= pop_n;
                  plvl_q      <= level;
                end
              end
              sfrb_pkg::REQ_FLUSH: begin
                wr_q          <= '0;
                rd_q          <= '0;
                frames_left_q <= '0;
                out_lvl_q     <= '0;
              end
              default: begin
              end
            endcase
          end
        end
        ST_POP: begin
          if (emit) begin
            out_valid_q <= 1'b1;
            out_left_q  <= rdata_q.left;
            out_right_q <= rdata_q.right;
            out_fv_q    <= 1'b1;
            out_acc_q   <= 1'b0;
            out_last_q  <= (emit_q == WW'(1));
            out_lvl_q   <= plvl_q - 1'b1;
            plvl_q      <= plvl_q - 1'b1;
            emit_q      <= emit_q - 1'b1;
            if (emit_q == WW'(1)) begin
              state_q <= ST_IDLE;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign lvl_ext = {{LW{1'b0}}, out_lvl_q};

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {6'b0, lvl_ext[LW-1:0], out_right_q, out_left_q};
  assign m_axis_tuser_o  = {out_acc_q, out_fv_q};
  assign m_axis_tlast_o  = out_last_q;

  a_pop_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_POP) |-> ((issue_q <= emit_q) && (emit_q != '0)))
    else $error("pop counters out of order");

  a_fetch_in_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rdv_q |-> ((state_q == ST_POP) && (emit_q > issue_q)))
    else $error("fetched frame outside a pop");

  a_packet_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {{AW{1'b0}}, frames_left_q} <= {{PW{1'b0}}, space})
    else $error("open packet exceeds free space");

  a_pop_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_POP) |-> ({{WW{1'b0}}, plvl_q} >= {{AW{1'b0}}, emit_q}))
    else $error("pop runs past ring level");

endmodule

/* tb/stereo_frame_ring_buffer_tb.sv */
`timescale 1ns / 100ps

module stereo_frame_ring_buffer_tb;

  localparam int unsigned RING     = 1024;
  localparam int unsigned MAX_POP  = 64;
  localparam logic [1:0]  REQ_IDLE = 2'd3;  // unused request code
  localparam int unsigned HOLD_CYC = 300;

  typedef struct packed {
    logic [1:0]                           req;
    logic                                 start;
    logic [sfrb_pkg::BYTES_W-1:0]         bytes;
    logic signed [sfrb_pkg::SAMPLE_W-1:0] left;
    logic signed [sfrb_pkg::SAMPLE_W-1:0] right;
    logic [sfrb_pkg::WANT_W-1:0]          want;
  } ring_req_t;

  typedef struct packed {
    logic signed [sfrb_pkg::SAMPLE_W-1:0] left;
    logic signed [sfrb_pkg::SAMPLE_W-1:0] right;
    logic                                 fv;
    logic                                 acc;
    logic [sfrb_pkg::LEVEL_W-1:0]         level;
    logic                                 last;
  } ring_beat_t;

  typedef struct {
    ring_req_t  rq;
    bit         typed;
    ring_beat_t beat;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata = '0;
  logic [2:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  // mirror of the ring
  sfrb_pkg::frame_t             mirror_frames [RING];
  logic [sfrb_pkg::LEVEL_W-1:0] wr_ptr = '0;
  logic [sfrb_pkg::LEVEL_W-1:0] rd_ptr = '0;
  bit                           pkt_open = 1'b0;
  int unsigned                  pkt_left = 0;

  ring_beat_t step_beats [$];
  ring_beat_t due_beats [$];
  dir_row_t   dir_tab [$];
  int         errors = 0;
  int         items_done = 0;
  bit         steady = 1'b0;
  bit         hold_arm = 1'b0;
  bit         hold_done = 1'b0;
  int         hold_left = 0;

  always #2 clk_i = ~clk_i;

  stereo_frame_ring_buffer u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tuser_o  (m_axis_tuser),
    .m_axis_tlast_o  (m_axis_tlast)
  );

  function automatic ring_req_t rq(logic [1:0] req, bit start, int bytes, int l, int r,
                                   int want);
    ring_req_t v;
    v.req   = req;
    v.start = start;
    v.bytes = bytes[sfrb_pkg::BYTES_W-1:0];
    v.left  = l[sfrb_pkg::SAMPLE_W-1:0];
    v.right = r[sfrb_pkg::SAMPLE_W-1:0];
    v.want  = want[sfrb_pkg::WANT_W-1:0];
    return v;
  endfunction

  function automatic ring_beat_t status_beat(int lvl, bit acc);
    ring_beat_t b;
    b       = '0;
    b.acc   = acc;
    b.level = lvl[sfrb_pkg::LEVEL_W-1:0];
    b.last  = 1'b1;
    return b;
  endfunction

  // Work out the result beats one request causes and advance the mirror.
  function automatic void ring_mirror_step(ring_req_t r);
    ring_beat_t                   b;
    int unsigned                  n;
    logic [sfrb_pkg::LEVEL_W-1:0] fill;
    sfrb_pkg::frame_t             f;
    step_beats.delete();
    fill = wr_ptr - rd_ptr;
    case (r.req)
      sfrb_pkg::REQ_PUSH: begin
        b = status_beat(0, 1'b0);
        if (r.start) begin
          n        = r.bytes >> 2;
          pkt_open = 1'b0;
          pkt_left = 0;
          if (n != 0 && n <= RING - 1 - fill) begin
            pkt_open = 1'b1;
            pkt_left = n;
          end
        end
        if (pkt_open && pkt_left != 0) begin
          mirror_frames[wr_ptr] = '{right: r.right, left: r.left};
          wr_ptr   = wr_ptr + 1'b1;
          pkt_left = pkt_left - 1;
          if (pkt_left == 0) pkt_open = 1'b0;
          b.acc = 1'b1;
        end
        b.level = wr_ptr - rd_ptr;
        step_beats.push_back(b);
      end
      sfrb_pkg::REQ_POP: begin
        n = (r.want > MAX_POP) ? MAX_POP : r.want;
        if (n > fill) n = fill;
        if (n == 0) begin
          step_beats.push_back(status_beat(fill, 1'b0));
        end else begin
          for (int i = 0; i < n; i++) begin
            f       = mirror_frames[rd_ptr];
            rd_ptr  = rd_ptr + 1'b1;
            b       = '0;
            b.left  = f.left;
            b.right = f.right;
            b.fv    = 1'b1;
            b.level = wr_ptr - rd_ptr;
            b.last  = (i + 1 == n);
            step_beats.push_back(b);
          end
        end
      end
      sfrb_pkg::REQ_FLUSH: begin
        wr_ptr   = '0;
        rd_ptr   = '0;
        pkt_open = 1'b0;
        pkt_left = 0;
        step_beats.push_back(status_beat(0, 1'b0));
      end
      default: step_beats.push_back(status_beat(fill, 1'b0));
    endcase
  endfunction

  function automatic void check_field(string name, logic [15:0] exp_v, logic [15:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s expected %0h got %0h", name, exp_v, got_v);
      errors++;
    end
  endfunction

  // Offer one beat, wait for the handshake, then queue its results.
  task automatic run_item(ring_req_t r, bit typed = 1'b0, ring_beat_t t = '0);
    if (!steady) begin
      while ($urandom_range(99) < 22) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, r.want, r.right, r.left, r.bytes};
    s_axis_tuser  <= {r.start, r.req};
    do @(posedge clk_i); while (!s_axis_tready);
    ring_mirror_step(r);
    if (typed) due_beats.push_back(t);
    else foreach (step_beats[i]) due_beats.push_back(step_beats[i]);
    items_done++;
  endtask

  task automatic send_packet(int bytes, int frames);
    for (int i = 0; i < frames; i++) begin
      run_item(rq(sfrb_pkg::REQ_PUSH, i == 0, (i == 0) ? bytes : $urandom_range(1023),
                  $urandom, $urandom, $urandom_range(127)));
    end
  endtask

  // receiver: random stalls plus one long hold-off
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left     <= hold_left - 1;
    end else if (hold_arm && !hold_done) begin
      m_axis_tready <= 1'b0;
      hold_left     <= HOLD_CYC;
      hold_done     <= 1'b1;
    end else begin
      m_axis_tready <= steady || ($urandom_range(99) >= 22);
    end
  end

  always @(posedge clk_i) begin : result_check
    ring_beat_t got;
    ring_beat_t exp_b;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.left  = m_axis_tdata[15:0];
      got.right = m_axis_tdata[31:16];
      got.level = m_axis_tdata[41:32];
      got.fv    = m_axis_tuser[0];
      got.acc   = m_axis_tuser[1];
      got.last  = m_axis_tlast;
      if (due_beats.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
      end else begin
        exp_b = due_beats.pop_front();
        check_field("left_out", exp_b.left, got.left);
        check_field("right_out", exp_b.right, got.right);
        check_field("frame_valid", exp_b.fv, got.fv);
        check_field("push_accepted", exp_b.acc, got.acc);
        check_field("level", exp_b.level, got.level);
        check_field("last", exp_b.last, got.last);
      end
    end
  end

  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin : stimulus
    int mix_end;
    int pick;
    int bytes;
    int n;

    // empty ring, stray frames, zero-length packet
    dir_tab.push_back('{rq(sfrb_pkg::REQ_POP, 0, 0, 0, 0, 0), 1'b1, status_beat(0, 0)});
    dir_tab.push_back('{rq(sfrb_pkg::REQ_POP, 0, 0, 0, 0, 5), 1'b1, status_beat(0, 0)});
    dir_tab.push_back('{rq(REQ_IDLE, 1, 1023, -1, -1, 127), 1'b1, status_beat(0, 0)});
    dir_tab.push_back('{rq(sfrb_pkg::REQ_PUSH, 0, 1023, 1, 1, 0), 1'b1,
                        status_beat(0, 0)});
    dir_tab.push_back('{rq(sfrb_pkg::REQ_PUSH, 1, 3, 7, 7, 0), 1'b1, status_beat(0, 0)});
    // three-frame packet at the sample extremes, then a surplus frame
    dir_tab.push_back('{rq(sfrb_pkg::REQ_PUSH, 1, 12, -32768, 32767, 0), 1'b1,
                        status_beat(1, 1)});
    dir_tab.push_back('{rq(sfrb_pkg::REQ_PUSH, 0, 0, 32767, -32768, 0), 1'b1,
                        status_beat(2, 1)});
    dir_tab.push_back('{rq(sfrb_pkg::REQ_PUSH, 0, 0, 0, -1, 0), 1'b1, status_beat(3, 1)});
    dir_tab.push_back('{rq(sfrb_pkg::REQ_PUSH, 0, 0, 5, 5, 0), 1'b1,
                        status_beat(3, 1'b0)});
    dir_tab.push_back('{rq(sfrb_pkg::REQ_POP, 0, 0, 0, 0, 1), 1'b0, '0});
    // a new start closes the open packet early
    dir_tab.push_back('{rq(sfrb_pkg::REQ_PUSH, 1, 1023, 16'h5555, 16'haaaa, 0), 1'b0,
                        '0});
    dir_tab.push_back('{rq(sfrb_pkg::REQ_PUSH, 1, 8, 16'h1234, 16'h4321, 0), 1'b0, '0});
    dir_tab.push_back('{rq(sfrb_pkg::REQ_PUSH, 0, 0, -2, 2, 0), 1'b0, '0});
    dir_tab.push_back('{rq(sfrb_pkg::REQ_POP, 0, 0, 0, 0, 127), 1'b0, '0});
    dir_tab.push_back('{rq(sfrb_pkg::REQ_FLUSH, 1, 1023, -1, -1, 127), 1'b1,
                        status_beat(0, 0)});
    dir_tab.push_back('{rq(sfrb_pkg::REQ_POP, 0, 0, 0, 0, 3), 1'b1, status_beat(0, 0)});
    dir_tab.push_back('{rq(sfrb_pkg::REQ_PUSH, 1, 16, -1, -1, 0), 1'b0, '0});
    dir_tab.push_back('{rq(sfrb_pkg::REQ_PUSH, 0, 0, 100, -100, 0), 1'b0, '0});
    dir_tab.push_back('{rq(sfrb_pkg::REQ_PUSH, 0, 0, -300, 300, 0), 1'b0, '0});
    dir_tab.push_back('{rq(sfrb_pkg::REQ_FLUSH, 0, 0, 0, 0, 0), 1'b1, status_beat(0, 0)});
    dir_tab.push_back('{rq(sfrb_pkg::REQ_PUSH, 0, 0, 9, 9, 0), 1'b1, status_beat(0, 0)});
    dir_tab.push_back('{rq(sfrb_pkg::REQ_PUSH, 1, 4, 16'h7ff0, 16'h800f, 0), 1'b0, '0});
    dir_tab.push_back('{rq(sfrb_pkg::REQ_POP, 0, 0, 0, 0, 64), 1'b0, '0});
    dir_tab.push_back('{rq(REQ_IDLE, 0, 0, 0, 0, 0), 1'b1, status_beat(0, 0)});

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) run_item(dir_tab[i].rq, dir_tab[i].typed, dir_tab[i].beat);

    // run without idling: a long packet cut short, a surplus frame, a fresh packet
    steady <= 1'b1;
    send_packet(1023, 40);
    send_packet(12, 3);
    send_packet(4, 2);
    send_packet(1023, 6);
    steady <= 1'b0;

    mix_end = items_done + 180;
    while (items_done < mix_end) begin
      if (items_done > mix_end - 150) hold_arm <= 1'b1;
      pick = $urandom_range(99);
      if (pick < 50) begin
        bytes = ($urandom_range(99) < 80) ? $urandom_range(0, 64) : $urandom_range(0, 1023);
        n     = bytes >> 2;
        pick  = $urandom_range(99);
        if (pick < 15) n = n + $urandom_range(1, 3);
        else if (pick < 30) n = $urandom_range(0, n);
        if (n == 0) n = 1;
        if (n > mix_end - items_done) n = mix_end - items_done;
        send_packet(bytes, n);
      end else if (pick < 75) begin
        run_item(rq(sfrb_pkg::REQ_POP, $urandom_range(1), $urandom, $urandom, $urandom,
                    ($urandom_range(99) < 85) ? $urandom_range(0, 64)
                                              : $urandom_range(65, 127)));
      end else if (pick < 80) begin
        run_item(rq(sfrb_pkg::REQ_FLUSH, $urandom_range(1), $urandom, $urandom, $urandom,
                    $urandom));
      end else if (pick < 85) begin
        run_item(rq(REQ_IDLE, $urandom_range(1), $urandom, $urandom, $urandom, $urandom));
      end else begin
        run_item(rq(sfrb_pkg::REQ_PUSH, 0, $urandom, $urandom, $urandom, $urandom));
      end
    end
    s_axis_tvalid <= 1'b0;

    while (due_beats.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (due_beats.size() != 0) begin
      $error("%0d result beats never arrived", due_beats.size());
      errors++;
    end
    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
